// ----- rtl/spa_pkg.sv -----
// Shared types and constants for the sparse polynomial adder.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package spa_pkg;

  localparam int MAX_TERMS_DEF = 32;
  localparam int EXP_W         = 16;
  localparam int COEF_W        = 32;
  localparam int TERM_W        = EXP_W + COEF_W;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PRIME,
    ST_MERGE
  } spa_state_t;

  typedef struct packed {
    logic load_en;
    logic prime;
    logic merge_en;
  } spa_cmd_t;

  typedef struct packed {
    logic close_req;
    logic final_fire;
  } spa_sts_t;

endpackage

// ----- rtl/sparse_polynomial_add.sv -----
// Sparse polynomial adder: loads two term lists one request per cycle, then
// merges them through the term RAM read ports at one sum term per cycle when
// the output does not stall. Closing the second list enters the prime, then
// the merge state; sum terms pass the pending, then the output register. No
// request is taken during the merge. Synchronous reset clears counts, flags
// and state; the term RAMs are not cleared. Depends on spa_pkg.
`timescale 1ns / 1ps

module sparse_polynomial_add #(
  parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_opcode,
  input  logic                              in_term_valid,
  input  logic [spa_pkg::EXP_W-1:0]         in_exponent,
  input  logic signed [spa_pkg::COEF_W-1:0] in_coefficient,
  input  logic                              in_last_term,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [spa_pkg::EXP_W-1:0]         out_sum_exponent,
  output logic signed [spa_pkg::COEF_W-1:0] out_sum_coefficient,
  output logic                              out_empty_sum,
  output logic                              out_capacity_error,
  output logic                              out_last_result
);

  import spa_pkg::*;

  spa_cmd_t cmd;
  spa_sts_t sts;

  spa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  spa_datapath #(.MAX_TERMS(MAX_TERMS)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_opcode           (in_opcode),
    .in_term_valid       (in_term_valid),
    .in_exponent         (in_exponent),
    .in_coefficient      (in_coefficient),
    .in_last_term        (in_last_term),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sum_exponent    (out_sum_exponent),
    .out_sum_coefficient (out_sum_coefficient),
    .out_empty_sum       (out_empty_sum),
    .out_capacity_error  (out_capacity_error),
    .out_last_result     (out_last_result)
  );

endmodule

// ----- rtl/spa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module spa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/spa_ctrl.sv -----
// Controller state machine: load, read priming and merge phases.
// Depends on spa_pkg.
`timescale 1ns / 1ps

module spa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spa_pkg::spa_sts_t sts,
  output spa_pkg::spa_cmd_t cmd
);

  import spa_pkg::*;

  spa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_stall     = 1'b1;
    case (state_r)
      ST_LOAD: begin
        in_stall    = 1'b0;
        cmd.load_en = in_valid;
        if (in_valid && sts.close_req) begin
          state_nxt = ST_PRIME;
        end
      end
      ST_PRIME: begin
        cmd.prime = 1'b1;
        state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        cmd.merge_en = 1'b1;
        if (sts.final_fire) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PRIME) |=> (state_r == ST_MERGE))
    else $error("prime not followed by merge");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) && in_valid && sts.close_req |=> (state_r == ST_PRIME))
    else $error("closing request did not start merge");

  assert property (@(posedge clk) disable iff (!rst_n)
    sts.final_fire |-> (state_r == ST_MERGE))
    else $error("final result outside merge");

endmodule

// ----- rtl/spa_datapath.sv -----
// Datapath: term stores, counts, merge indices, adder with saturation,
// pending and output registers. Depends on spa_pkg and spa_ram.
`timescale 1ns / 1ps

module spa_datapath #(
  parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  spa_pkg::spa_cmd_t                cmd,
  output spa_pkg::spa_sts_t                sts,
  input  logic                             in_opcode,
  input  logic                             in_term_valid,
  input  logic [spa_pkg::EXP_W-1:0]        in_exponent,
  input  logic signed [spa_pkg::COEF_W-1:0] in_coefficient,
  input  logic                             in_last_term,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [spa_pkg::EXP_W-1:0]        out_sum_exponent,
  output logic signed [spa_pkg::COEF_W-1:0] out_sum_coefficient,
  output logic                             out_empty_sum,
  output logic                             out_capacity_error,
  output logic                             out_last_result
);

  import spa_pkg::*;

  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_TERMS);
  localparam logic [CW-1:0] ONE  = CW'(1);

  // load bookkeeping
  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic          closed_r, closed_nxt, ovf_r, ovf_nxt;
  logic          we_a, we_b;
  logic [TERM_W-1:0] wdata, rdata_a, rdata_b;

  // merge
  logic [CW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [AW-1:0] raddr_a, raddr_b;
  logic          a_has, b_has, exhausted;
  logic [EXP_W-1:0]         ea, eb;
  logic signed [COEF_W-1:0] ca, cb;
  logic signed [COEF_W:0]   sum_w;
  logic signed [COEF_W-1:0] sum_sat;
  logic                     cand_valid, adv_a, adv_b;
  logic [EXP_W-1:0]         cand_exp;
  logic signed [COEF_W-1:0] cand_coef;
  logic                     out_free, step, push_pend, final_fire;

  logic                     pend_valid_r, pend_valid_nxt;
  logic [EXP_W-1:0]         pend_exp_r, pend_exp_nxt;
  logic signed [COEF_W-1:0] pend_coef_r, pend_coef_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [EXP_W-1:0]         out_exp_r, out_exp_nxt;
  logic signed [COEF_W-1:0] out_coef_r, out_coef_nxt;
  logic                     out_empty_r, out_empty_nxt;
  logic                     out_cap_r, out_cap_nxt;
  logic                     out_last_r, out_last_nxt;

  assign wdata = {in_exponent, in_coefficient};

  spa_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a_r[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  spa_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b_r[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  assign ea = rdata_a[TERM_W-1:COEF_W];
  assign eb = rdata_b[TERM_W-1:COEF_W];
  assign ca = signed'(rdata_a[COEF_W-1:0]);
  assign cb = signed'(rdata_b[COEF_W-1:0]);

  assign sum_w = {ca[COEF_W-1], ca} + {cb[COEF_W-1], cb};

  always_comb begin
    if (sum_w[COEF_W] != sum_w[COEF_W-1]) begin
      sum_sat = sum_w[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end else begin
      sum_sat = sum_w[COEF_W-1:0];
    end
  end

  assign a_has     = (a_r < cnt_a_r);
  assign b_has     = (b_r < cnt_b_r);
  assign exhausted = !a_has && !b_has;

  always_comb begin
    cand_valid = 1'b0;
    cand_exp   = ea;
    cand_coef  = ca;
    adv_a      = 1'b0;
    adv_b      = 1'b0;
    if (a_has && b_has) begin
      if (ea < eb) begin
        cand_valid = 1'b1;
        cand_exp   = eb;
        cand_coef  = cb;
        adv_b      = 1'b1;
      end else if (ea > eb) begin
        cand_valid = 1'b1;
        adv_a      = 1'b1;
      end else begin
        cand_valid = (sum_sat != '0);
        cand_coef  = sum_sat;
        adv_a      = 1'b1;
        adv_b      = 1'b1;
      end
    end else if (a_has) begin
      cand_valid = 1'b1;
      adv_a      = 1'b1;
    end else if (b_has) begin
      cand_valid = 1'b1;
      cand_exp   = eb;
      cand_coef  = cb;
      adv_b      = 1'b1;
    end
  end

  assign out_free   = !out_valid_r || !out_stall;
  assign step       = cmd.merge_en && !exhausted && (!cand_valid || !pend_valid_r || out_free);
  assign push_pend  = step && cand_valid && pend_valid_r;
  assign final_fire = cmd.merge_en && exhausted && out_free;

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    if (cmd.prime) begin
      a_nxt = '0;
      b_nxt = '0;
    end else if (step) begin
      if (adv_a) a_nxt = a_r + ONE;
      if (adv_b) b_nxt = b_r + ONE;
    end
  end

  assign raddr_a = a_nxt[AW-1:0];
  assign raddr_b = b_nxt[AW-1:0];

  // load path
  always_comb begin
    cnt_a_nxt  = cnt_a_r;
    cnt_b_nxt  = cnt_b_r;
    closed_nxt = closed_r;
    ovf_nxt    = ovf_r;
    we_a       = 1'b0;
    we_b       = 1'b0;
    if (cmd.load_en) begin
      if (!in_opcode) begin
        if (!closed_r) begin
          if (in_term_valid) begin
            if (cnt_a_r == FULL) begin
              ovf_nxt = 1'b1;
            end else begin
              we_a      = 1'b1;
              cnt_a_nxt = cnt_a_r + ONE;
            end
          end
          if (in_last_term) closed_nxt = 1'b1;
        end
      end else if (in_term_valid) begin
        if (cnt_b_r == FULL) begin
          ovf_nxt = 1'b1;
        end else begin
          we_b      = 1'b1;
          cnt_b_nxt = cnt_b_r + ONE;
        end
      end
    end
    if (final_fire) begin
      cnt_a_nxt  = '0;
      cnt_b_nxt  = '0;
      closed_nxt = 1'b0;
      ovf_nxt    = 1'b0;
    end
  end

  // pending term and output register
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_exp_nxt   = pend_exp_r;
    pend_coef_nxt  = pend_coef_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_exp_nxt    = out_exp_r;
    out_coef_nxt   = out_coef_r;
    out_empty_nxt  = out_empty_r;
    out_cap_nxt    = out_cap_r;
    out_last_nxt   = out_last_r;
    if (step && cand_valid) begin
      pend_valid_nxt = 1'b1;
      pend_exp_nxt   = cand_exp;
      pend_coef_nxt  = cand_coef;
    end
    if (push_pend) begin
      out_valid_nxt = 1'b1;
      out_exp_nxt   = pend_exp_r;
      out_coef_nxt  = pend_coef_r;
      out_empty_nxt = 1'b0;
      out_cap_nxt   = ovf_r;
      out_last_nxt  = 1'b0;
    end
    if (final_fire) begin
      pend_valid_nxt = 1'b0;
      out_valid_nxt  = 1'b1;
      out_cap_nxt    = ovf_r;
      out_last_nxt   = 1'b1;
      out_empty_nxt  = !pend_valid_r;
      out_exp_nxt    = pend_valid_r ? pend_exp_r : '0;
      out_coef_nxt   = pend_valid_r ? pend_coef_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r      <= '0;
      cnt_b_r      <= '0;
      closed_r     <= 1'b0;
      ovf_r        <= 1'b0;
      a_r          <= '0;
      b_r          <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cnt_a_r      <= cnt_a_nxt;
      cnt_b_r      <= cnt_b_nxt;
      closed_r     <= closed_nxt;
      ovf_r        <= ovf_nxt;
      a_r          <= a_nxt;
      b_r          <= b_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_exp_r  <= pend_exp_nxt;
    pend_coef_r <= pend_coef_nxt;
    out_exp_r   <= out_exp_nxt;
    out_coef_r  <= out_coef_nxt;
    out_empty_r <= out_empty_nxt;
    out_cap_r   <= out_cap_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign sts.close_req  = in_opcode && in_last_term;
  assign sts.final_fire = final_fire;

  assign out_valid           = out_valid_r;
  assign out_sum_exponent    = out_exp_r;
  assign out_sum_coefficient = out_coef_r;
  assign out_empty_sum       = out_empty_r;
  assign out_capacity_error  = out_cap_r;
  assign out_last_result     = out_last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    final_fire |=> out_valid_r && out_last_r && !pend_valid_r)
    else $error("final result not loaded");

  assert property (@(posedge clk) disable iff (!rst_n)
    final_fire |=> (cnt_a_r == '0) && (cnt_b_r == '0) && !closed_r && !ovf_r)
    else $error("state not cleared after merge");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> out_last_r && (out_exp_r == '0) && (out_coef_r == '0))
    else $error("malformed empty marker");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.merge_en |-> (a_r <= cnt_a_r) && (b_r <= cnt_b_r))
    else $error("merge index past count");

endmodule
